@@ hdl/hmgi_pkg.sv @@
// ----------------------------------------------------------------------------
// hmgi_pkg
// Shared constants and types for the get-or-insert hash map.
// ----------------------------------------------------------------------------
package hmgi_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 64;

  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_UPDATE
  } hmgi_state_t;

endpackage

@@ hdl/hmgi_in_if.sv @@
// ----------------------------------------------------------------------------
// hmgi_in_if
// Request channel: mode, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmgi_in_if;
  import hmgi_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);

endinterface

@@ hdl/hmgi_out_if.sv @@
// ----------------------------------------------------------------------------
// hmgi_out_if
// Result channel: found flag, value and full flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmgi_out_if;
  import hmgi_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] result_value;
  logic             bucket_full;

  modport source (output valid, output found, output result_value, output bucket_full,
                  input ready);
  modport sink   (input valid, input found, input result_value, input bucket_full,
                  output ready);

endinterface

@@ hdl/hash_map_get_or_insert.sv @@
// Overlap: when the output register is free, a new request is taken in the update state
//   of the last one, so the write-back overlaps the next hash.
// Latency: request accept, bucket hash, registered row read, then the result register.
// A waiting result does not stop idle acceptance; the next update stalls until it is taken.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every bucket row
//   while in_ch.ready stays low.
// ----------------------------------------------------------------------------
// hash_map_get_or_insert
// Get-or-insert key/value map with WAYS ways per bucket, no deletion. Each
// bucket is one memory row holding its fill count and all ways, so a request
// is one row read, a parallel compare and at most one row write.
// ----------------------------------------------------------------------------
module hash_map_get_or_insert #(
  parameter int BUCKETS = hmgi_pkg::BUCKETS_DEF,
  parameter int WAYS    = hmgi_pkg::WAYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hmgi_in_if.sink    in_ch,
  hmgi_out_if.source out_ch
);
  import hmgi_pkg::*;

  localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);

  typedef struct packed {
    logic [FILL_W-1:0]           fill;
    logic [WAYS-1:0][KEY_W-1:0]  keys;
    logic [WAYS-1:0][VAL_W-1:0]  vals;
  } row_t;

  hmgi_state_t state_r, state_nxt;

  logic [BIDX_W-1:0] clr_cnt_r;
  logic              clr_last;

  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  value_r;
  logic [BIDX_W-1:0] bkt_r;

  logic              in_acc;
  logic              h_done;
  logic [BIDX_W-1:0] h_bucket;

  row_t              mem [BUCKETS];
  row_t              rd_row_r;
  logic              rd_en;
  logic              wr_en;
  logic [BIDX_W-1:0] wr_addr;
  row_t              wr_row;
  row_t              ins_row;

  logic [WAYS-1:0]   hit;
  logic [VAL_W-1:0]  hit_val;
  logic              found;
  logic              full;
  logic              do_insert;
  logic              out_free;
  logic              upd_go;

  logic              out_valid_r;
  logic              out_found_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_full_r;

  hmgi_bucket_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .key_i    (in_ch.key),
    .done     (h_done),
    .bucket_o (h_bucket)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign upd_go      = (state_r == ST_UPDATE) && out_free;
  assign in_ch.ready = (state_r == ST_IDLE) || upd_go;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign clr_last    = (clr_cnt_r == BIDX_W'(BUCKETS - 1));

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (h_done) begin
          rd_en     = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = in_acc ? ST_HASH : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLEAR && !clr_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // request fields, held until the row update
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_ch.mode;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
    if (rd_en) begin
      bkt_r <= h_bucket;
    end
  end

  // bucket row memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[h_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // compare all live ways of the bucket
  always_comb begin
    hit_val = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = (FILL_W'(w) < rd_row_r.fill) && (rd_row_r.keys[w] == key_r);
      if (hit[w]) begin
        hit_val = hit_val | rd_row_r.vals[w];
      end
    end
  end

  assign found     = |hit;
  assign full      = (rd_row_r.fill >= FILL_W'(WAYS));
  assign do_insert = (mode_r == MODE_INSERT) && !found && !full;

  always_comb begin
    ins_row      = rd_row_r;
    ins_row.fill = rd_row_r.fill + 1'b1;
    ins_row.keys[rd_row_r.fill[WAY_W-1:0]] = key_r;
    ins_row.vals[rd_row_r.fill[WAY_W-1:0]] = value_r;
  end

  // clearing pass zeroes fill counts; otherwise append on insert
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_row  = '0;
    end else begin
      wr_en   = upd_go && do_insert;
      wr_addr = bkt_r;
      wr_row  = ins_row;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_found_r <= found;
      out_full_r  <= (mode_r == MODE_INSERT) && !found && full;
      if (found) begin
        out_value_r <= hit_val;
      end else if (do_insert) begin
        out_value_r <= value_r;
      end else begin
        out_value_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.bucket_full  = out_full_r;

endmodule

@@ hdl/hmgi_bucket_hash.sv @@
// ----------------------------------------------------------------------------
// hmgi_bucket_hash
// Bucket index = key mod BUCKETS. Power-of-two counts take a mask in one
// register stage; other counts use a four stage reciprocal multiply with
// one final correction.
// ----------------------------------------------------------------------------
module hmgi_bucket_hash #(
  parameter int BUCKETS = hmgi_pkg::BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hmgi_pkg::KEY_W-1:0]   key_i,
  output logic                         done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket_o
);
  import hmgi_pkg::*;

  localparam int  BIDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      logic              v_r;
      logic [BIDX_W-1:0] bucket_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= 1'b0;
        end else begin
          v_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          bucket_r <= (BUCKETS == 1) ? '0 : key_i[BIDX_W-1:0];
        end
      end

      assign done     = v_r;
      assign bucket_o = bucket_r;
    end else begin : g_recip
      // floor(2^48 / BUCKETS); quotient estimate is off by at most one
      localparam logic [48:0] TWO48 = 49'h1_0000_0000_0000;
      localparam logic [47:0] RECIP = 48'(TWO48 / BUCKETS);
      localparam logic [31:0] BMUL  = 32'(BUCKETS);

      logic [3:0]        v_r;
      logic [63:0]       p_lo_r;
      logic [63:0]       p_hi_r;
      logic [KEY_W-1:0]  key1_r;
      logic [KEY_W-1:0]  key2_r;
      logic [KEY_W-1:0]  key3_r;
      logic [31:0]       q_r;
      logic [31:0]       qb_r;
      logic [BIDX_W-1:0] bucket_r;
      logic [79:0]       prod;
      logic [31:0]       rem;
      logic [31:0]       rem_fix;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= '0;
        end else begin
          v_r <= {v_r[2:0], start};
        end
      end

      assign prod    = {p_hi_r, 16'd0} + {16'd0, p_lo_r};
      assign rem     = key3_r - qb_r;
      assign rem_fix = (rem >= BMUL) ? (rem - BMUL) : rem;

      always_ff @(posedge clk) begin
        p_lo_r   <= {16'd0, RECIP} * {48'd0, key_i[15:0]};
        p_hi_r   <= {16'd0, RECIP} * {48'd0, key_i[31:16]};
        key1_r   <= key_i;
        q_r      <= prod[79:48];
        key2_r   <= key1_r;
        qb_r     <= 32'(q_r * BMUL);
        key3_r   <= key2_r;
        bucket_r <= rem_fix[BIDX_W-1:0];
      end

      assign done     = v_r[3];
      assign bucket_o = bucket_r;
    end
  endgenerate

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the get-or-insert hash map. Requests go in through
// a bursty sender and results are checked in order against a local model of
// the bucket table. Directed cases cover misses, hits, zero values, key
// extremes and bucket overflow; random traffic is aimed at a small set of
// hot buckets so that hits, inserts and full buckets all occur often.
// ----------------------------------------------------------------------------
module tb_top;
  import hmgi_pkg::*;

  localparam int BUCKETS      = BUCKETS_DEF;
  localparam int WAYS         = WAYS_DEF;
  localparam int RANDOM_ITEMS = 1285;
  localparam int IDLE_LIMIT   = 8000;
  localparam int HOT_BUCKETS  = 24;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic             full;
  } map_result_t;

  logic clk;
  logic rst_n;

  hmgi_in_if  in_if ();
  hmgi_out_if out_if ();

  hash_map_get_or_insert #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // local copy of the bucket table
  int unsigned      fill_cnt [BUCKETS];
  logic [KEY_W-1:0] way_key  [BUCKETS*WAYS];
  logic [VAL_W-1:0] way_val  [BUCKETS*WAYS];

  map_result_t      lookup_results_q [$];
  logic [KEY_W-1:0] stored_keys [$];
  int               mismatch_cnt;
  int               burst_left;

  // sink side stall pattern
  int sink_style;
  int sink_style_left;
  int sink_stall_left;

  always #1 clk = ~clk;

  function automatic map_result_t predict_request(logic m, logic [KEY_W-1:0] k,
                                                  logic [VAL_W-1:0] v);
    map_result_t r;
    int unsigned b;
    int unsigned base;
    b    = k % BUCKETS;
    base = b * WAYS;
    r    = '0;
    for (int w = 0; w < fill_cnt[b]; w++) begin
      if (way_key[base + w] == k) begin
        r.found = 1'b1;
        r.value = way_val[base + w];
        return r;
      end
    end
    if (m == MODE_INSERT) begin
      if (fill_cnt[b] >= WAYS) begin
        r.full = 1'b1;
      end else begin
        way_key[base + fill_cnt[b]] = k;
        way_val[base + fill_cnt[b]] = v;
        fill_cnt[b]++;
        stored_keys.push_back(k);
        r.value = v;
      end
    end
    return r;
  endfunction

  task automatic send_request(logic m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    map_result_t exp_r;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.key   <= k;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    exp_r = predict_request(m, k, v);
    lookup_results_q.push_back(exp_r);
  endtask

  // hold off the sender until every outstanding transaction has returned
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (lookup_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_lookups();
    send_request(MODE_LOOKUP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    wait_results_drained();
  endtask

  task automatic test_insert_and_hit();
    // zero stored value still reports found
    send_request(MODE_INSERT, 32'h0000_0000, 64'h0);
    send_request(MODE_LOOKUP, 32'h0000_0000, 64'hDEAD_BEEF_0000_0001);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // existing key is not overwritten
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 64'h5);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0);
    send_request(MODE_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000);
    wait_results_drained();
  endtask

  task automatic test_bucket_overflow();
    logic [KEY_W-1:0] kb;
    kb = 32'h0000_0155;
    for (int i = 0; i < WAYS; i++) begin
      send_request(MODE_INSERT, kb + i * BUCKETS, {$urandom, $urandom});
    end
    send_request(MODE_INSERT, 32'hFFFF_FC00 | kb, 64'h1234);
    // miss on a full bucket is a plain miss
    send_request(MODE_LOOKUP, 32'hFFFF_FC00 | kb, 64'h0);
    send_request(MODE_INSERT, kb + (WAYS - 1) * BUCKETS, 64'hAAAA);
    send_request(MODE_LOOKUP, kb, 64'h0);
    send_request(MODE_INSERT, 32'h0000_0400, 64'h7);
    send_request(MODE_LOOKUP, 32'h0000_0400, 64'h0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned      hot [HOT_BUCKETS];
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    logic             m;
    foreach (hot[i]) hot[i] = $urandom_range(0, BUCKETS - 1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 && stored_keys.size() != 0) begin
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (sel < 80) begin
        k = ($urandom & ~(BUCKETS - 1)) | hot[$urandom_range(0, HOT_BUCKETS - 1)];
      end else begin
        k = $urandom;
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) v = '0;
      else if (sel == 1) v = '1;
      else v = {$urandom, $urandom};
      m = ($urandom_range(0, 9) < 7) ? MODE_INSERT : MODE_LOOKUP;
      send_request(m, k, v);
      if (n == RANDOM_ITEMS / 2) wait_results_drained();
    end
    wait_results_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    map_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lookup_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: found=%0b value=%h full=%0b",
                   out_if.found, out_if.result_value, out_if.bucket_full);
      end else begin
        exp_r = lookup_results_q.pop_front();
        if (out_if.found !== exp_r.found || out_if.result_value !== exp_r.value ||
            out_if.bucket_full !== exp_r.full) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: exp found=%0b value=%h full=%0b, got found=%0b value=%h full=%0b",
                     exp_r.found, exp_r.value, exp_r.full,
                     out_if.found, out_if.result_value, out_if.bucket_full);
        end
      end
    end
  end

  // receiver stall pattern, picks a new style when its style counter runs out
  always @(posedge clk) begin
    if (sink_style_left == 0) begin
      sink_style      = $urandom_range(0, 3);
      sink_style_left = $urandom_range(100, 300);
    end else begin
      sink_style_left--;
    end
    case (sink_style)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        if (sink_stall_left > 0) begin
          sink_stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) sink_stall_left = $urandom_range(1, 10);
        end
      end
      default: begin
        out_if.ready <= ~out_if.ready;
      end
    endcase
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_LOOKUP;
    in_if.key       = '0;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
    mismatch_cnt    = 0;
    burst_left      = 0;
    sink_style      = 0;
    sink_style_left = 0;
    sink_stall_left = 0;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_lookups();
    test_insert_and_hit();
    test_bucket_overflow();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && lookup_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hmgi_pkg.sv
hdl/hmgi_in_if.sv
hdl/hmgi_out_if.sv
hdl/hmgi_bucket_hash.sv
hdl/hash_map_get_or_insert.sv
tb/tb_top.sv
